FILE: hw/rtl/fpdp_pkg.sv
// Shared constants, request/response structs and the reduction schedule for the
// eight-lane fp32 dot product. Used by fpdp_fma and the top level; no dependencies.
package fpdp_pkg;

  localparam int unsigned AccumLanes = 8;
  localparam int unsigned HalfLanes  = AccumLanes / 2;
  localparam int unsigned LaneIdxW   = $clog2(AccumLanes);
  localparam int unsigned RedSteps   = 7;

  localparam logic [31:0] FpOne    = 32'h3F80_0000;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  // Request to the shared fused multiply-add unit: result = a * b + c.
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } fma_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fma_rsp_t;

  // One reduction step: load the addend lane into a holding register, then add it
  // into the accumulating lane, which also receives the sum.
  typedef struct packed {
    logic [LaneIdxW-1:0] load_idx;
    logic [LaneIdxW-1:0] acc_idx;
  } red_step_t;

  function automatic red_step_t red_step(input logic [2:0] k);
    red_step_t s;
    case (k)
      3'd0:    begin s.load_idx = 3'd4; s.acc_idx = 3'd0; end
      3'd1:    begin s.load_idx = 3'd5; s.acc_idx = 3'd1; end
      3'd2:    begin s.load_idx = 3'd6; s.acc_idx = 3'd2; end
      3'd3:    begin s.load_idx = 3'd7; s.acc_idx = 3'd3; end
      3'd4:    begin s.load_idx = 3'd1; s.acc_idx = 3'd0; end
      3'd5:    begin s.load_idx = 3'd3; s.acc_idx = 3'd2; end
      default: begin s.load_idx = 3'd2; s.acc_idx = 3'd0; end
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/fpdp_fma.sv
// Multi-cycle fp32 fused multiply-add, round to nearest even, subnormals kept.
// Depends on fpdp_pkg for the request and response structs.
module fpdp_fma (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpdp_pkg::fma_req_t req_i,
  output fpdp_pkg::fma_rsp_t rsp_o
);

  localparam int unsigned MW = 48;
  localparam int unsigned GW = 26;
  localparam int unsigned SW = MW + GW + 1;
  localparam int unsigned NormSteps = 7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UNPACK, ST_MUL, ST_ALIGN, ST_ADD, ST_DENORM, ST_NORM, ST_ROUND
  } state_e;

  typedef struct packed {
    logic        s;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [23:0] m;
    logic [9:0]  e;
  } unp_t;

  function automatic unp_t unpack(input logic [31:0] x);
    unp_t        u;
    logic [23:0] m;
    logic [4:0]  lz;
    logic [9:0]  e_eff;
    m  = {x[30:23] != 8'd0, x[22:0]};
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    e_eff  = (x[30:23] == 8'd0) ? 10'd1 : {2'b00, x[30:23]};
    u.s    = x[31];
    u.nan  = (&x[30:23]) && (|x[22:0]);
    u.inf  = (&x[30:23]) && !(|x[22:0]);
    u.zero = (x[30:0] == 31'd0);
    u.m    = m << lz;
    u.e    = e_eff - {5'd0, lz};
    return u;
  endfunction

  function automatic logic [SW-1:0] shr_sticky(input logic [SW-1:0] v, input logic [6:0] sh);
    logic [SW-1:0] mask;
    logic [SW-1:0] r;
    mask = ~({SW{1'b1}} << sh);
    r    = v >> sh;
    r[0] = r[0] | (|(v & mask));
    return r;
  endfunction

  state_e        state_q;
  logic [2:0]    step_q;
  logic          done_q;
  logic [31:0]   result_q;

  logic [31:0]   op_a_q, op_b_q, op_c_q;
  logic [23:0]   ma_q, mb_q, mc_q;
  logic [9:0]    ea_q, eb_q, ec_q;
  logic          ps_q, sc_q, czero_q;
  logic [MW-1:0] prod_q;
  logic [10:0]   ep_q, ecx_q;
  logic [SW-1:0] al_a_q, al_b_q;
  logic [10:0]   eal_q;
  logic          sa_q, sb_q;
  logic [SW-1:0] s_q;
  logic [11:0]   e_q;
  logic          sign_q;

  // Unpack and special cases.
  unp_t        ua, ub, uc;
  logic        prod_inf, prod_zero, ps, is_nan, is_special;
  logic [31:0] special_res;

  always_comb begin
    ua = unpack(op_a_q);
    ub = unpack(op_b_q);
    uc = unpack(op_c_q);
    ps        = ua.s ^ ub.s;
    prod_inf  = ua.inf | ub.inf;
    prod_zero = ua.zero | ub.zero;
    is_nan    = ua.nan | ub.nan | uc.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero) |
                (prod_inf & uc.inf & (ps != uc.s));
    is_special = is_nan | prod_inf | uc.inf | prod_zero;
    if (is_nan) begin
      special_res = fpdp_pkg::CanonNan;
    end else if (prod_inf) begin
      special_res = {ps, 8'hFF, 23'd0};
    end else if (uc.inf) begin
      special_res = op_c_q;
    end else if (uc.zero) begin
      special_res = {ps & uc.s, 31'd0};
    end else begin
      special_res = op_c_q;
    end
  end

  // Alignment: the operand with the larger exponent stays, the other shifts right.
  logic          swap;
  logic [MW-1:0] mc_ext, big_m, small_m;
  logic [10:0]   big_e, small_e, diff_e;
  logic [6:0]    al_sh;

  always_comb begin
    mc_ext  = {mc_q, 24'd0};
    swap    = !czero_q && ($signed(ecx_q) > $signed(ep_q));
    big_m   = swap ? mc_ext : prod_q;
    small_m = swap ? prod_q : (czero_q ? '0 : mc_ext);
    big_e   = swap ? ecx_q : ep_q;
    small_e = swap ? ep_q : ecx_q;
    diff_e  = big_e - small_e;
    al_sh   = (diff_e >= 11'(SW)) ? 7'(SW) : diff_e[6:0];
  end

  // Add or subtract magnitudes.
  logic [SW:0]   diff_w;
  logic [SW-1:0] sum_v;
  logic          sum_sign;

  always_comb begin
    diff_w = {1'b0, al_a_q} - {1'b0, al_b_q};
    if (sa_q == sb_q) begin
      sum_v    = al_a_q + al_b_q;
      sum_sign = sa_q;
    end else if (diff_w[SW]) begin
      sum_v    = al_b_q - al_a_q;
      sum_sign = sb_q;
    end else begin
      sum_v    = diff_w[SW-1:0];
      sum_sign = sa_q;
    end
  end

  // Denormalize and bounded left normalize.
  logic [11:0] dn_sh_w;
  logic [6:0]  dn_sh, nk;
  logic [11:0] e_minus;
  logic        norm_ok;

  always_comb begin
    dn_sh_w = 12'd1 - e_q;
    dn_sh   = (dn_sh_w >= 12'(SW)) ? 7'(SW) : dn_sh_w[6:0];
    nk      = 7'd64 >> step_q;
    e_minus = e_q - {5'd0, nk};
    norm_ok = ((s_q >> (7'(SW) - nk)) == '0) && ($signed(e_minus) >= 12'sd1);
  end

  // Rounding and packing.
  logic [23:0] mant;
  logic        rnd;
  logic [24:0] m25;
  logic [23:0] mant_f;
  logic [11:0] e_r;
  logic [31:0] packed_res;

  always_comb begin
    mant   = s_q[SW-1 -: 24];
    rnd    = s_q[SW-25] & ((|s_q[SW-26:0]) | mant[0]);
    m25    = {1'b0, mant} + {24'd0, rnd};
    mant_f = m25[24] ? m25[24:1] : m25[23:0];
    e_r    = e_q + {11'd0, m25[24]};
    if ($signed(e_r) >= 12'sd255) begin
      packed_res = {sign_q, 8'hFF, 23'd0};
    end else if (!mant_f[23]) begin
      packed_res = {sign_q, 8'd0, mant_f[22:0]};
    end else begin
      packed_res = {sign_q, e_r[7:0], mant_f[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (req_i.start) state_q <= ST_UNPACK;
        end
        ST_UNPACK: begin
          if (is_special) begin
            result_q <= special_res;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:   state_q <= ST_ALIGN;
        ST_ALIGN: state_q <= ST_ADD;
        ST_ADD: begin
          if (sum_v == '0) begin
            // Exact cancellation of nonzero terms gives positive zero.
            result_q <= 32'd0;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_DENORM;
          end
        end
        ST_DENORM: begin
          step_q  <= '0;
          state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (step_q == 3'(NormSteps - 1)) state_q <= ST_ROUND;
          step_q <= step_q + 3'd1;
        end
        ST_ROUND: begin
          result_q <= packed_res;
          done_q   <= 1'b1;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          op_a_q <= req_i.a;
          op_b_q <= req_i.b;
          op_c_q <= req_i.c;
        end
      end
      ST_UNPACK: begin
        ma_q    <= ua.m;
        mb_q    <= ub.m;
        mc_q    <= uc.m;
        ea_q    <= ua.e;
        eb_q    <= ub.e;
        ec_q    <= uc.e;
        ps_q    <= ps;
        sc_q    <= uc.s;
        czero_q <= uc.zero;
      end
      ST_MUL: begin
        prod_q <= ma_q * mb_q;
        ep_q   <= {ea_q[9], ea_q} + {eb_q[9], eb_q};
        // The addend is scaled so both terms share the product's exponent base.
        ecx_q  <= {ec_q[9], ec_q} + 11'd126;
      end
      ST_ALIGN: begin
        al_a_q <= {1'b0, big_m, {GW{1'b0}}};
        al_b_q <= shr_sticky({1'b0, small_m, {GW{1'b0}}}, al_sh);
        eal_q  <= big_e;
        sa_q   <= swap ? sc_q : ps_q;
        sb_q   <= swap ? ps_q : sc_q;
      end
      ST_ADD: begin
        s_q    <= sum_v;
        sign_q <= sum_sign;
        e_q    <= {eal_q[10], eal_q} - 12'd125;
      end
      ST_DENORM: begin
        if ($signed(e_q) < 12'sd1) begin
          s_q <= shr_sticky(s_q, dn_sh);
          e_q <= 12'd1;
        end
      end
      ST_NORM: begin
        if (norm_ok) begin
          s_q <= s_q << nk;
          e_q <= e_minus;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

endmodule

FILE: hw/rtl/fp32_dot_product_eight_lane_top.sv
// Channel  Direction  Signals                                          Word
// in       input      in_valid_i, in_ready_o, lhs_bits_i, rhs_bits_i,  one element pair
//                     last_element_i
// out      output     out_valid_o, out_ready_i, product_sum_bits_o     one inner product
//
// Every fused multiply-add and add goes through one shared fpdp_fma unit.
// A held pair is only stored; the fourth pair of a half group fuses all four of its pairs into lanes.
// The last pair adds 7 reduction ops plus one op per leftover pair.
// Reset is asynchronous and clears the lanes, the group position and the output register.
// A finished sum waits in the output register; the next vector may run meanwhile.
module fp32_dot_product_eight_lane_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] lhs_bits_i,
  input  logic [31:0] rhs_bits_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] product_sum_bits_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LANE, ST_LANE_WAIT, ST_RED_LOAD, ST_RED, ST_RED_WAIT,
    ST_TAIL, ST_TAIL_WAIT, ST_EMIT
  } state_e;

  localparam int unsigned Lanes = fpdp_pkg::AccumLanes;
  localparam int unsigned LW    = fpdp_pkg::LaneIdxW;

  state_e      state_q;
  logic [31:0] lane_q [Lanes];
  logic [63:0] pend_q [3];
  logic [2:0]  pos_q;
  logic [2:0]  cnt_q;
  logic        base_q;
  logic [1:0]  n_q;
  logic        last_q;
  logic [31:0] a_q, b_q, hold_q;
  logic        out_valid_q;
  logic [31:0] out_bits_q;

  fpdp_pkg::fma_req_t  fma_req;
  fpdp_pkg::fma_rsp_t  fma_rsp;
  fpdp_pkg::red_step_t rstep;

  logic          accept;
  logic [1:0]    sub;
  logic [LW-1:0] lane_idx, rd_idx, wr_idx;
  logic [63:0]   pend_rd;
  logic [31:0]   lane_rd;
  logic          emit_go;

  assign accept  = (state_q == ST_IDLE) && in_valid_i;
  assign sub     = pos_q[1:0];
  assign rstep   = fpdp_pkg::red_step(cnt_q);
  assign lane_idx = {base_q, cnt_q[1:0]};
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pend_rd = pend_q[0];
      2'd1:    pend_rd = pend_q[1];
      default: pend_rd = pend_q[2];
    endcase
  end

  always_comb begin
    case (state_q)
      ST_LANE, ST_LANE_WAIT: begin rd_idx = lane_idx;       wr_idx = lane_idx;      end
      ST_RED_LOAD:           begin rd_idx = rstep.load_idx; wr_idx = rstep.acc_idx; end
      ST_RED, ST_RED_WAIT:   begin rd_idx = rstep.acc_idx;  wr_idx = rstep.acc_idx; end
      default:               begin rd_idx = '0;             wr_idx = '0;            end
    endcase
  end

  assign lane_rd = lane_q[rd_idx];

  always_comb begin
    fma_req.start = 1'b0;
    fma_req.a     = pend_rd[63:32];
    fma_req.b     = pend_rd[31:0];
    fma_req.c     = lane_rd;
    case (state_q)
      ST_LANE: begin
        fma_req.start = 1'b1;
        if (cnt_q == 3'd3) begin
          fma_req.a = a_q;
          fma_req.b = b_q;
        end
      end
      ST_RED: begin
        // Additions run as hold * 1.0 + lane, which rounds exactly once.
        fma_req.start = 1'b1;
        fma_req.a     = hold_q;
        fma_req.b     = fpdp_pkg::FpOne;
      end
      ST_TAIL: fma_req.start = 1'b1;
      default: ;
    endcase
  end

  fpdp_fma u_fma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fma_req),
    .rsp_o  (fma_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      last_q      <= 1'b0;
      base_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_bits_q  <= '0;
      for (int i = 0; i < Lanes; i++) lane_q[i] <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !emit_go) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q  <= '0;
            last_q <= last_element_i;
            base_q <= pos_q[2];
            if (sub != 2'd3) begin
              pos_q <= pos_q + 3'd1;
              if (last_element_i) begin
                n_q     <= sub + 2'd1;
                state_q <= ST_RED_LOAD;
              end
            end else begin
              state_q <= ST_LANE;
            end
          end
        end
        ST_LANE: state_q <= ST_LANE_WAIT;
        ST_LANE_WAIT: begin
          if (fma_rsp.done) begin
            lane_q[wr_idx] <= fma_rsp.result;
            if (cnt_q == 3'd3) begin
              pos_q <= pos_q + 3'd1;
              cnt_q <= '0;
              n_q   <= '0;
              state_q <= last_q ? ST_RED_LOAD : ST_IDLE;
            end else begin
              cnt_q   <= cnt_q + 3'd1;
              state_q <= ST_LANE;
            end
          end
        end
        ST_RED_LOAD: state_q <= ST_RED;
        ST_RED:      state_q <= ST_RED_WAIT;
        ST_RED_WAIT: begin
          if (fma_rsp.done) begin
            lane_q[wr_idx] <= fma_rsp.result;
            if (cnt_q == 3'(fpdp_pkg::RedSteps - 1)) begin
              if (n_q == 2'd0) begin
                state_q <= ST_EMIT;
              end else begin
                // Leftover pairs are fused newest first.
                cnt_q   <= {1'b0, n_q - 2'd1};
                state_q <= ST_TAIL;
              end
            end else begin
              cnt_q   <= cnt_q + 3'd1;
              state_q <= ST_RED_LOAD;
            end
          end
        end
        ST_TAIL: state_q <= ST_TAIL_WAIT;
        ST_TAIL_WAIT: begin
          if (fma_rsp.done) begin
            lane_q[0] <= fma_rsp.result;
            if (cnt_q == 3'd0) begin
              state_q <= ST_EMIT;
            end else begin
              cnt_q   <= cnt_q - 3'd1;
              state_q <= ST_TAIL;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            if ((&lane_q[0][30:23]) && (|lane_q[0][22:0])) begin
              out_bits_q <= fpdp_pkg::CanonNan;
            end else begin
              out_bits_q <= lane_q[0];
            end
            pos_q       <= '0;
            for (int i = 0; i < Lanes; i++) lane_q[i] <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (sub != 2'd3) begin
        pend_q[sub] <= {lhs_bits_i, rhs_bits_i};
      end else begin
        a_q <= lhs_bits_i;
        b_q <= rhs_bits_i;
      end
    end
    if (state_q == ST_RED_LOAD) hold_q <= lane_rd;
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign product_sum_bits_o = out_bits_q;

endmodule
